[hw/rtl/mvc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register codes and constants for the moisture valve controller.
package mvc_pkg;

	// Raw readings above this count as bone dry.
	localparam int unsigned CLAMP_MAX    = 550;
	// pct = (550 - r) * 100 / 550 = (550 - r) * 2 / 11, done as (d * 11916) >> 16.
	localparam int unsigned PCT_RECIP    = 11916;
	localparam int unsigned PCT_SHIFT    = 16;
	localparam int unsigned PROD_W       = 24;

	localparam int unsigned CHANNELS_DEF = 3;
	localparam int unsigned MAX_CHANNELS = 8;

	localparam logic [6:0]  LOW_RESET    = 7'd45;
	localparam logic [6:0]  HIGH_RESET   = 7'd55;
	localparam logic [31:0] REST_RESET   = 32'd122000;
	localparam logic [31:0] LIMIT_RESET  = 32'd2000;

	typedef enum logic [2:0] {
		REG_LOW_0      = 3'd0,
		REG_LOW_1      = 3'd1,
		REG_LOW_2      = 3'd2,
		REG_HIGH_0     = 3'd3,
		REG_HIGH_1     = 3'd4,
		REG_HIGH_2     = 3'd5,
		REG_REST       = 3'd6,
		REG_OPEN_LIMIT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  channel;
		logic [9:0]  raw_reading;
		logic [31:0] now_ms;
	} mvc_in_t;

	typedef struct packed {
		logic [6:0] moisture_percent;
		logic       valve_drive;
		logic [2:0] valves_open;
	} mvc_out_t;

endpackage

[hw/rtl/moisture_valve_controller.sv]
`timescale 1ns / 1ps
// Top level of the moisture valve controller: percent mapping and valve state.
//
// One input transfer carries a channel, a raw 10-bit soil reading and a
// millisecond time stamp; it yields exactly one result transfer with the
// mapped moisture (0 driest .. 100 wettest), the new drive level of that
// channel's valve and the open flags of valves 0 to 2. The block takes one
// item per clock while in_stall is low: the percent mapping (a single
// constant multiply) sits in front of the input register, and the valve
// decision with its 32-bit elapsed-time compare sits between the input
// register and the result register, so the throughput is one item per
// cycle. Valve state and the last opening time update as an item moves into
// the result register, so the next item already sees them. A new item is
// taken while a finished result still waits; in_stall rises only when both
// registers are full and out_stall is high. Configuration writes are to be
// made while the block is idle. Channels at or above CHANNELS leave the
// state alone and drive 0; a channel above 2 uses the fixed thresholds 45/55.
module moisture_valve_controller #(
	parameter int unsigned CHANNELS = mvc_pkg::CHANNELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  mvc_pkg::mvc_in_t  in_item,
	output logic            out_valid,
	input  logic            out_stall,
	output mvc_pkg::mvc_out_t out_item,
	input  logic            cfg_write,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import mvc_pkg::*;

	// configuration registers
	logic [6:0]  low_q  [3];
	logic [6:0]  high_q [3];
	logic [31:0] rest_q;
	logic [31:0] limit_q;

	// valve state
	logic [CHANNELS-1:0] valve_open_q;
	logic [31:0]         last_open_q;

	// stage 1: accepted item with percent already mapped
	logic        valid_s1;
	logic [1:0]  channel_s1;
	logic [6:0]  pct_s1;
	logic [31:0] now_s1;

	// stage 2: result register
	logic     valid_s2;
	mvc_out_t result_s2;

	logic              in_xfer;
	logic              advance;
	logic [9:0]        raw_clamped;
	logic [9:0]        dry_span;
	logic [PROD_W-1:0] pct_prod;
	logic [6:0]        pct_in;

	logic [6:0]  low_sel;
	logic [6:0]  high_sel;
	logic        chan_ok;
	logic [7:0]  open_ext;
	logic [7:0]  chan_bit;
	logic [7:0]  open_next;
	logic [31:0] elapsed;
	logic        do_open;
	logic        do_close;

	// ---- input side: clamp and map to percent ----
	always_comb begin
		raw_clamped = (in_item.raw_reading > 10'(CLAMP_MAX)) ? 10'(CLAMP_MAX)
		                                                    : in_item.raw_reading;
		dry_span    = 10'(CLAMP_MAX) - raw_clamped;
		pct_prod    = PROD_W'(dry_span) * PROD_W'(PCT_RECIP);
		pct_in      = pct_prod[PCT_SHIFT +: 7];
	end

	// s1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			channel_s1 <= in_item.channel;
			pct_s1     <= pct_in;
			now_s1     <= in_item.now_ms;
		end
	end

	// ---- valve decision ----
	always_comb begin
		case (channel_s1)
			2'd0:    begin low_sel = low_q[0];  high_sel = high_q[0]; end
			2'd1:    begin low_sel = low_q[1];  high_sel = high_q[1]; end
			2'd2:    begin low_sel = low_q[2];  high_sel = high_q[2]; end
			default: begin low_sel = LOW_RESET; high_sel = HIGH_RESET; end
		endcase
	end

	always_comb begin
		open_ext                 = '0;
		open_ext[CHANNELS-1:0]   = valve_open_q;
		chan_ok                  = 4'(channel_s1) < 4'(CHANNELS);
		chan_bit                 = 8'd1 << channel_s1;
		elapsed                  = now_s1 - last_open_q;  // wraps mod 2^32

		do_open  = (pct_s1 < low_sel) && (open_ext == '0) && (elapsed > rest_q);
		do_close = ((pct_s1 > high_sel) && ((open_ext & chan_bit) != '0))
		           || (elapsed > limit_q);

		open_next = open_ext;
		if (chan_ok) begin
			if (do_open) begin
				open_next = open_ext | chan_bit;
			end else if (do_close) begin
				open_next = open_ext & ~chan_bit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_open_q <= '0;
			last_open_q  <= '0;
		end else if (advance) begin
			valve_open_q <= open_next[CHANNELS-1:0];
			if (chan_ok && do_open) begin
				last_open_q <= now_s1;
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.moisture_percent <= pct_s1;
			result_s2.valve_drive      <= chan_ok && ((open_next & chan_bit) != '0);
			result_s2.valves_open      <= open_next[2:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

	// ---- configuration writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '{LOW_RESET, LOW_RESET, LOW_RESET};
			high_q  <= '{HIGH_RESET, HIGH_RESET, HIGH_RESET};
			rest_q  <= REST_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_0:      low_q[0]  <= cfg_data[6:0];
				REG_LOW_1:      low_q[1]  <= cfg_data[6:0];
				REG_LOW_2:      low_q[2]  <= cfg_data[6:0];
				REG_HIGH_0:     high_q[0] <= cfg_data[6:0];
				REG_HIGH_1:     high_q[1] <= cfg_data[6:0];
				REG_HIGH_2:     high_q[2] <= cfg_data[6:0];
				REG_REST:       rest_q    <= cfg_data;
				REG_OPEN_LIMIT: limit_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

endmodule
